### design/taae_pkg.sv
// taae_pkg: shared types, command codes and fixed byte strings for the
// text attribute to ansi escape encoder
// no dependencies
package taae_pkg;

  typedef logic [7:0] byte_t;

  // decimal split of an 8-bit value
  typedef struct packed {
    logic [1:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
  } dec_t;

  localparam int MAX_BYTES = 27;
  localparam int INIT_LEN = 27;
  localparam int FINISH_LEN = 8;

  // command codes
  localparam logic [2:0] KIND_CHAR    = 3'd0;
  localparam logic [2:0] KIND_COLOUR  = 3'd1;
  localparam logic [2:0] KIND_POS     = 3'd2;
  localparam logic [2:0] KIND_SAVE    = 3'd3;
  localparam logic [2:0] KIND_RESTORE = 3'd4;
  localparam logic [2:0] KIND_START   = 3'd5;
  localparam logic [2:0] KIND_FINISH  = 3'd6;

  // remembered colour state codes
  localparam logic [3:0] COLOUR_UNKNOWN = 4'd8;
  localparam logic [2:0] REND_UNKNOWN   = 3'd7;
  localparam logic [2:0] REND_NORMAL    = 3'd0;
  localparam logic [2:0] REND_BOLD      = 3'd1;
  localparam logic [2:0] REND_BLINK     = 3'd5;

  // ascii bytes
  localparam byte_t CH_ESC  = 8'h1B;
  localparam byte_t CH_LBR  = 8'h5B;
  localparam byte_t CH_SEMI = 8'h3B;
  localparam byte_t CH_0    = 8'h30;
  localparam byte_t CH_1    = 8'h31;
  localparam byte_t CH_3    = 8'h33;
  localparam byte_t CH_4    = 8'h34;
  localparam byte_t CH_5    = 8'h35;
  localparam byte_t CH_M    = 8'h6D;
  localparam byte_t CH_H    = 8'h48;
  localparam byte_t CH_S    = 8'h73;
  localparam byte_t CH_U    = 8'h75;

  localparam byte_t INIT_SEQ [INIT_LEN] = '{
    8'h1B, 8'h5B, 8'h6D, 8'h1B, 8'h5D, 8'h52, 8'h1B, 8'h5D, 8'h52,
    8'h1B, 8'h5B, 8'h48, 8'h1B, 8'h5B, 8'h4A,
    8'h1B, 8'h5B, 8'h30, 8'h3B, 8'h31, 8'h30, 8'h3B, 8'h31, 8'h3B,
    8'h31, 8'h31, 8'h6D
  };

  localparam byte_t FINISH_SEQ [FINISH_LEN] = '{
    8'h1B, 8'h5B, 8'h31, 8'h30, 8'h6D, 8'h1B, 8'h5B, 8'h6D
  };

  // vga colour order to ansi order: swap bits 0 and 2
  function automatic logic [2:0] swap_colour(input logic [2:0] c);
    return {c[0], c[1], c[2]};
  endfunction

  // ascii digit from a 4-bit value
  function automatic byte_t digit(input logic [3:0] d);
    return {4'h3, d};
  endfunction

  // hundreds, tens, ones; tens by reciprocal multiply (exact below 1029)
  function automatic dec_t dec_split(input logic [7:0] v);
    dec_t        d;
    logic [7:0]  rem;
    logic [14:0] prod;
    if (v >= 8'd200) begin
      d.hun = 2'd2;
      rem   = v - 8'd200;
    end else if (v >= 8'd100) begin
      d.hun = 2'd1;
      rem   = v - 8'd100;
    end else begin
      d.hun = 2'd0;
      rem   = v;
    end
    prod  = {8'd0, rem[6:0]} * 15'd205;
    d.ten = prod[14:11];
    d.one = 4'(rem - {4'd0, d.ten} * 8'd10);
    return d;
  endfunction

endpackage

### design/text_attribute_to_ansi_escape_encoder.sv
// text_attribute_to_ansi_escape_encoder: top level, turns commands into an
// ansi terminal byte stream
// depends on taae_pkg
//
// Each accepted command is expanded at once into its full byte string (up to
// 27 bytes), which is loaded into a byte shift register and sent out one word
// per cycle while out_ready is high; out_last_byte marks the final word of a
// command. A command that produces words gives from 1 to 27 of them, and the
// next command is accepted in the same cycle the last word of the current one
// is taken, so back-to-back single-word commands (plain characters) run at one
// per cycle when out_ready stays high. Commands that produce no words (an
// unchanged colour, kind 7) are accepted whenever the output is empty or
// draining its last word. The throughput limit is the single byte-wide output
// port fed by the shift register. Colour state (previous foreground, background
// and rendition) is updated when the colour or start command is accepted, so it
// always reflects commands in order. blink_as_bold is written through the
// cfg channel, which is always ready; write it only while the block is idle.
module text_attribute_to_ansi_escape_encoder (
  input  logic       clk,
  input  logic       rst_n,
  // command channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_attribute,
  input  logic [7:0] in_column,
  input  logic [7:0] in_row,
  // byte stream channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_byte,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_blink_as_bold
);

  localparam int CntW = $clog2(taae_pkg::MAX_BYTES + 1);
  localparam int IdxW = $clog2(taae_pkg::MAX_BYTES);

  // output shift register, word 0 is on the port
  taae_pkg::byte_t buf_r [taae_pkg::MAX_BYTES];
  logic [CntW-1:0] cnt_r;

  // colour state and config
  logic [3:0] prev_fg_r, prev_fg_nxt;
  logic [3:0] prev_bg_r, prev_bg_nxt;
  logic [2:0] prev_at_r, prev_at_nxt;
  logic       blink_as_bold_r;

  // byte string for the command on the input
  taae_pkg::byte_t seq_bytes [taae_pkg::MAX_BYTES];
  logic [IdxW-1:0] n;
  logic [CntW-1:0] seq_len;
  logic            full;

  // colour decode
  logic [2:0] fg, bg, at;
  logic       fg_bright, fg_ch, bg_ch;
  taae_pkg::dec_t row_d, col_d;

  logic in_acc, out_acc;

  assign cfg_ready = 1'b1;

  assign out_valid     = (cnt_r != '0);
  assign out_byte      = buf_r[0];
  assign out_last_byte = (cnt_r == CntW'(1));
  assign out_acc       = out_valid && out_ready;

  // free, or the last word of the current string leaves this cycle
  assign in_ready = (cnt_r == '0) || ((cnt_r == CntW'(1)) && out_ready);
  assign in_acc   = in_valid && in_ready;

  // colour mapping
  assign fg        = taae_pkg::swap_colour(in_attribute[2:0]);
  assign bg        = taae_pkg::swap_colour(in_attribute[6:4]);
  assign fg_bright = in_attribute[3];
  assign at        = in_attribute[7] ? (blink_as_bold_r ? taae_pkg::REND_BOLD
                                                        : taae_pkg::REND_BLINK)
                                     : (fg_bright ? taae_pkg::REND_BOLD
                                                  : taae_pkg::REND_NORMAL);
  assign fg_ch     = ({1'b0, fg} != prev_fg_r);
  assign bg_ch     = ({1'b0, bg} != prev_bg_r);

  assign row_d = taae_pkg::dec_split(in_row);
  assign col_d = taae_pkg::dec_split(in_column);

  // build the string; n is the next free slot, full marks a 27-byte string
  always_comb begin
    for (int i = 0; i < taae_pkg::MAX_BYTES; i++) begin
      seq_bytes[i] = 8'h00;
    end
    n           = '0;
    full        = 1'b0;
    prev_fg_nxt = prev_fg_r;
    prev_bg_nxt = prev_bg_r;
    prev_at_nxt = prev_at_r;
    case (in_kind)
      taae_pkg::KIND_CHAR: begin
        // two control codes are remapped to printable ones
        if (in_char_code == 8'd22) begin
          seq_bytes[0] = 8'd254;
        end else if (in_char_code == 8'd15) begin
          seq_bytes[0] = 8'd14;
        end else begin
          seq_bytes[0] = in_char_code;
        end
        n = IdxW'(1);
      end
      taae_pkg::KIND_COLOUR: begin
        if (!(at == prev_at_r && !fg_ch && !bg_ch)) begin
          seq_bytes[n] = taae_pkg::CH_ESC; n = n + 1'b1;
          seq_bytes[n] = taae_pkg::CH_LBR; n = n + 1'b1;
          if (at == prev_at_r) begin
            // rendition kept, only colours that moved
            if (fg_ch) begin
              seq_bytes[n] = taae_pkg::CH_3; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::digit({1'b0, fg}); n = n + 1'b1;
            end
            if (fg_ch && bg_ch) begin
              seq_bytes[n] = taae_pkg::CH_SEMI; n = n + 1'b1;
            end
            if (bg_ch) begin
              seq_bytes[n] = taae_pkg::CH_4; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::digit({1'b0, bg}); n = n + 1'b1;
            end
          end else if (at != taae_pkg::REND_NORMAL) begin
            if (at == taae_pkg::REND_BLINK && fg_bright) begin
              seq_bytes[n] = taae_pkg::CH_1; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::CH_SEMI; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::CH_5; n = n + 1'b1;
            end else if (prev_at_r == taae_pkg::REND_BLINK) begin
              seq_bytes[n] = taae_pkg::CH_0; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::CH_SEMI; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::CH_1; n = n + 1'b1;
            end else begin
              seq_bytes[n] = taae_pkg::digit({1'b0, at}); n = n + 1'b1;
            end
            if (fg_ch) begin
              seq_bytes[n] = taae_pkg::CH_SEMI; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::CH_3; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::digit({1'b0, fg}); n = n + 1'b1;
            end
            if (bg_ch) begin
              seq_bytes[n] = taae_pkg::CH_SEMI; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::CH_4; n = n + 1'b1;
              seq_bytes[n] = taae_pkg::digit({1'b0, bg}); n = n + 1'b1;
            end
          end else begin
            // back to normal: full reset plus both colours
            seq_bytes[n] = taae_pkg::CH_0; n = n + 1'b1;
            seq_bytes[n] = taae_pkg::CH_SEMI; n = n + 1'b1;
            seq_bytes[n] = taae_pkg::CH_3; n = n + 1'b1;
            seq_bytes[n] = taae_pkg::digit({1'b0, fg}); n = n + 1'b1;
            seq_bytes[n] = taae_pkg::CH_SEMI; n = n + 1'b1;
            seq_bytes[n] = taae_pkg::CH_4; n = n + 1'b1;
            seq_bytes[n] = taae_pkg::digit({1'b0, bg}); n = n + 1'b1;
          end
          seq_bytes[n] = taae_pkg::CH_M; n = n + 1'b1;
          prev_fg_nxt = {1'b0, fg};
          prev_bg_nxt = {1'b0, bg};
          prev_at_nxt = at;
        end
      end
      taae_pkg::KIND_POS: begin
        seq_bytes[n] = taae_pkg::CH_ESC; n = n + 1'b1;
        seq_bytes[n] = taae_pkg::CH_LBR; n = n + 1'b1;
        if (in_row >= 8'd100) begin
          seq_bytes[n] = taae_pkg::digit({2'b00, row_d.hun}); n = n + 1'b1;
        end
        if (in_row >= 8'd10) begin
          seq_bytes[n] = taae_pkg::digit(row_d.ten); n = n + 1'b1;
        end
        seq_bytes[n] = taae_pkg::digit(row_d.one); n = n + 1'b1;
        seq_bytes[n] = taae_pkg::CH_SEMI; n = n + 1'b1;
        if (in_column >= 8'd100) begin
          seq_bytes[n] = taae_pkg::digit({2'b00, col_d.hun}); n = n + 1'b1;
        end
        if (in_column >= 8'd10) begin
          seq_bytes[n] = taae_pkg::digit(col_d.ten); n = n + 1'b1;
        end
        seq_bytes[n] = taae_pkg::digit(col_d.one); n = n + 1'b1;
        seq_bytes[n] = taae_pkg::CH_H; n = n + 1'b1;
      end
      taae_pkg::KIND_SAVE: begin
        seq_bytes[0] = taae_pkg::CH_ESC;
        seq_bytes[1] = taae_pkg::CH_LBR;
        seq_bytes[2] = taae_pkg::CH_S;
        n = IdxW'(3);
      end
      taae_pkg::KIND_RESTORE: begin
        seq_bytes[0] = taae_pkg::CH_ESC;
        seq_bytes[1] = taae_pkg::CH_LBR;
        seq_bytes[2] = taae_pkg::CH_U;
        n = IdxW'(3);
      end
      taae_pkg::KIND_START: begin
        // init string fills the whole buffer, colours forgotten
        for (int i = 0; i < taae_pkg::INIT_LEN; i++) begin
          seq_bytes[i] = taae_pkg::INIT_SEQ[i];
        end
        full        = 1'b1;
        prev_fg_nxt = taae_pkg::COLOUR_UNKNOWN;
        prev_bg_nxt = taae_pkg::COLOUR_UNKNOWN;
        prev_at_nxt = taae_pkg::REND_UNKNOWN;
      end
      taae_pkg::KIND_FINISH: begin
        for (int i = 0; i < taae_pkg::FINISH_LEN; i++) begin
          seq_bytes[i] = taae_pkg::FINISH_SEQ[i];
        end
        n = IdxW'(taae_pkg::FINISH_LEN);
      end
      default: begin
        // unused kind: no words, no state change
        n = '0;
      end
    endcase
  end

  assign seq_len = full ? CntW'(taae_pkg::MAX_BYTES) : CntW'(n);

  // control and colour state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r           <= '0;
      prev_fg_r       <= taae_pkg::COLOUR_UNKNOWN;
      prev_bg_r       <= taae_pkg::COLOUR_UNKNOWN;
      prev_at_r       <= taae_pkg::REND_UNKNOWN;
      blink_as_bold_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r     <= seq_len;
        prev_fg_r <= prev_fg_nxt;
        prev_bg_r <= prev_bg_nxt;
        prev_at_r <= prev_at_nxt;
      end else if (out_acc) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        blink_as_bold_r <= cfg_blink_as_bold;
      end
    end
  end

  // byte shift register, payload only
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < taae_pkg::MAX_BYTES; i++) begin
        buf_r[i] <= seq_bytes[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < taae_pkg::MAX_BYTES - 1; i++) begin
        buf_r[i] <= buf_r[i + 1];
      end
    end
  end

`ifndef SYNTHESIS
  // never take a command while more than one word is still pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > CntW'(1)) |-> !in_ready)
    else $error("command taken while string still pending");

  // count never runs past the buffer
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(taae_pkg::MAX_BYTES))
    else $error("word count past buffer depth");

  // output goes empty after the last word if nothing new came in
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_byte && !in_acc) |=> !out_valid)
    else $error("words left after last word taken");

  // start command forgets the colour state
  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == taae_pkg::KIND_START) |=>
      (prev_fg_r == taae_pkg::COLOUR_UNKNOWN && prev_bg_r == taae_pkg::COLOUR_UNKNOWN
       && prev_at_r == taae_pkg::REND_UNKNOWN))
    else $error("colour state not cleared by start");

  // rendition state only holds legal codes
  a_rend_legal: assert property (@(posedge clk) disable iff (!rst_n)
    prev_at_r == taae_pkg::REND_NORMAL || prev_at_r == taae_pkg::REND_BOLD ||
    prev_at_r == taae_pkg::REND_BLINK || prev_at_r == taae_pkg::REND_UNKNOWN)
    else $error("illegal rendition state");
`endif

endmodule

### verif/taae_stream_checker.sv
// taae_stream_checker: watches the command, byte and config channels of the
// encoder, predicts every output word and compares them in order
// depends on taae_pkg
module taae_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_attribute,
  input  logic [7:0] in_column,
  input  logic [7:0] in_row,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last_byte,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_blink_as_bold,
  output int         mismatches,
  output int         outstanding
);

  // character remaps
  localparam taae_pkg::byte_t CH_SYN   = 8'd22;
  localparam taae_pkg::byte_t CH_BLOCK = 8'd254;
  localparam taae_pkg::byte_t CH_SI    = 8'd15;
  localparam taae_pkg::byte_t CH_SO    = 8'd14;

  typedef struct {
    taae_pkg::byte_t data;
    logic            last;
  } word_t;

  word_t           expected_words[$];
  taae_pkg::byte_t burst[$];
  logic            bold_mode;
  logic [3:0]      last_fg;
  logic [3:0]      last_bg;
  logic [2:0]      last_rend;

  function automatic logic [2:0] vga_to_ansi(input logic [2:0] c);
    return {c[0], c[1], c[2]};
  endfunction

  function automatic void put_esc_text(input string s);
    burst.push_back(taae_pkg::CH_ESC);
    for (int i = 0; i < s.len(); i++) burst.push_back(taae_pkg::byte_t'(s[i]));
  endfunction

  function automatic void forget_colours();
    last_fg   = taae_pkg::COLOUR_UNKNOWN;
    last_bg   = taae_pkg::COLOUR_UNKNOWN;
    last_rend = taae_pkg::REND_UNKNOWN;
  endfunction

  // sgr delta against the remembered colours
  function automatic void encode_colour(input taae_pkg::byte_t attr);
    logic [2:0] fg;
    logic [2:0] bg;
    logic [2:0] rend;
    logic       fg_new;
    logic       bg_new;
    string      body;
    fg     = vga_to_ansi(attr[2:0]);
    bg     = vga_to_ansi(attr[6:4]);
    rend   = attr[3] ? taae_pkg::REND_BOLD : taae_pkg::REND_NORMAL;
    if (attr[7]) rend = bold_mode ? taae_pkg::REND_BOLD : taae_pkg::REND_BLINK;
    fg_new = {1'b0, fg} != last_fg;
    bg_new = {1'b0, bg} != last_bg;
    if (rend == last_rend && !fg_new && !bg_new) return;
    if (rend == last_rend) begin
      if (fg_new && bg_new) body = $sformatf("3%0d;4%0d", fg, bg);
      else if (bg_new) body = $sformatf("4%0d", bg);
      else body = $sformatf("3%0d", fg);
    end else if (rend != taae_pkg::REND_NORMAL) begin
      if (rend == taae_pkg::REND_BLINK && attr[3]) body = "1;5";
      else if (last_rend == taae_pkg::REND_BLINK) body = "0;1";
      else body = $sformatf("%0d", rend);
      if (fg_new) body = {body, $sformatf(";3%0d", fg)};
      if (bg_new) body = {body, $sformatf(";4%0d", bg)};
    end else begin
      body = $sformatf("0;3%0d;4%0d", fg, bg);
    end
    put_esc_text({"[", body, "m"});
    last_rend = rend;
    last_fg   = {1'b0, fg};
    last_bg   = {1'b0, bg};
  endfunction

  function automatic void encode_command(input logic [2:0] kind,
                                         input taae_pkg::byte_t ch,
                                         input taae_pkg::byte_t attr,
                                         input taae_pkg::byte_t col,
                                         input taae_pkg::byte_t row);
    burst.delete();
    case (kind)
      taae_pkg::KIND_CHAR: begin
        if (ch == CH_SYN) burst.push_back(CH_BLOCK);
        else if (ch == CH_SI) burst.push_back(CH_SO);
        else burst.push_back(ch);
      end
      taae_pkg::KIND_COLOUR:  encode_colour(attr);
      taae_pkg::KIND_POS:     put_esc_text($sformatf("[%0d;%0dH", row, col));
      taae_pkg::KIND_SAVE:    put_esc_text("[s");
      taae_pkg::KIND_RESTORE: put_esc_text("[u");
      taae_pkg::KIND_START: begin
        put_esc_text("[m");
        put_esc_text("]R");
        put_esc_text("]R");
        put_esc_text("[H");
        put_esc_text("[J");
        put_esc_text("[0;10;1;11m");
        forget_colours();
      end
      taae_pkg::KIND_FINISH: begin
        put_esc_text("[10m");
        put_esc_text("[m");
      end
      default: ;
    endcase
    foreach (burst[i]) expected_words.push_back(word_t'{burst[i], i == burst.size() - 1});
  endfunction

  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      bold_mode = 1'b0;
      forget_colours();
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) bold_mode = cfg_blink_as_bold;
      // queue first so a word of the same edge still finds its expectation
      if (in_valid && in_ready)
        encode_command(in_kind, in_char_code, in_attribute, in_column, in_row);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, actual byte %h last %b",
                   $time, out_byte, out_last_byte);
        end else begin
          w = expected_words.pop_front();
          if (out_byte !== w.data) begin
            mismatches++;
            $display("%0t: out_byte expected %h actual %h", $time, w.data, out_byte);
          end
          if (out_last_byte !== w.last) begin
            mismatches++;
            $display("%0t: out_last_byte expected %b actual %b",
                     $time, w.last, out_last_byte);
          end
        end
      end
    end
    outstanding = expected_words.size();
  end

endmodule

### verif/tb.sv
// tb: drives commands, config writes and output stalls into the encoder and
// gives the verdict from the checker's mismatch count
// depends on taae_pkg, taae_stream_checker and the encoder
module tb;

  // kind 7 carries no command, the block swallows it
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_kind;
  logic [7:0] in_char_code;
  logic [7:0] in_attribute;
  logic [7:0] in_column;
  logic [7:0] in_row;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last_byte;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_blink_as_bold;

  int              mismatches;
  int              outstanding;
  bit              calm;        // no gaps and no stalls while set
  taae_pkg::byte_t prior_attr;  // last colour attribute sent, seeds small deltas
  int              sent;        // commands sent in the current phase

  always #2 clk = ~clk;

  text_attribute_to_ansi_escape_encoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .in_attribute      (in_attribute),
    .in_column         (in_column),
    .in_row            (in_row),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_byte     (out_last_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_blink_as_bold (cfg_blink_as_bold)
  );

  taae_stream_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .in_attribute      (in_attribute),
    .in_column         (in_column),
    .in_row            (in_row),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_byte     (out_last_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_blink_as_bold (cfg_blink_as_bold),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one, two and three digit values in about equal share
  function automatic taae_pkg::byte_t pick_coord();
    case ($urandom_range(0, 2))
      0:       return taae_pkg::byte_t'($urandom_range(0, 9));
      1:       return taae_pkg::byte_t'($urandom_range(10, 99));
      default: return taae_pkg::byte_t'($urandom_range(100, 255));
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the command is taken
  task automatic send_cmd(input logic [2:0] kind, input taae_pkg::byte_t ch,
                          input taae_pkg::byte_t attr, input taae_pkg::byte_t col,
                          input taae_pkg::byte_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_char_code <= ch;
    in_attribute <= attr;
    in_column    <= col;
    in_row       <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending until the checker holds no expectation, then let the
  // block settle; outstanding is read off the falling edge
  task automatic drain_outputs(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_cfg(input logic bold);
    cfg_valid         <= 1'b1;
    cfg_blink_as_bold <= bold;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // well-formed command mix; colours lean on small deltas from the last one
  // so that every sgr branch, including the empty one, keeps coming up
  task automatic send_random();
    int              pick;
    logic [2:0]      kind;
    taae_pkg::byte_t ch;
    taae_pkg::byte_t attr;
    pick = $urandom_range(0, 99);
    ch   = taae_pkg::byte_t'($urandom);
    attr = taae_pkg::byte_t'($urandom);
    if (pick < 35) kind = taae_pkg::KIND_CHAR;
    else if (pick < 65) kind = taae_pkg::KIND_COLOUR;
    else if (pick < 75) kind = taae_pkg::KIND_POS;
    else if (pick < 80) kind = taae_pkg::KIND_SAVE;
    else if (pick < 85) kind = taae_pkg::KIND_RESTORE;
    else if (pick < 90) kind = taae_pkg::KIND_START;
    else if (pick < 95) kind = taae_pkg::KIND_FINISH;
    else kind = KIND_UNUSED;
    // the two remapped characters
    if (kind == taae_pkg::KIND_CHAR && $urandom_range(0, 7) == 0)
      ch = $urandom_range(0, 1) ? 8'd22 : 8'd15;
    if (kind == taae_pkg::KIND_COLOUR) begin
      case ($urandom_range(0, 4))
        0, 1:    ;
        2:       attr = {prior_attr[7:4], attr[3:0]};
        3:       attr = {attr[7:4], prior_attr[3:0]};
        default: attr = prior_attr;
      endcase
      prior_attr = attr;
    end
    send_cmd(kind, ch, attr, pick_coord(), pick_coord());
    if (kind != KIND_UNUSED) sent++;
  endtask

  // output side: ready runs broken by stalls, mostly short, a few long
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!calm) begin
        out_ready <= 1'b0;
        case ($urandom_range(0, 99)) inside
          [0:69]:  repeat ($urandom_range(1, 2)) @(posedge clk);
          [70:91]: repeat ($urandom_range(3, 6)) @(posedge clk);
          default: repeat ($urandom_range(15, 40)) @(posedge clk);
        endcase
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_kind           <= taae_pkg::KIND_CHAR;
    in_char_code      <= '0;
    in_attribute      <= '0;
    in_column         <= '0;
    in_row            <= '0;
    cfg_valid         <= 1'b0;
    cfg_blink_as_bold <= 1'b0;
    calm              = 1'b0;
    prior_attr        = 8'h07;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: blink_as_bold at its reset value of 0
    send_cmd(taae_pkg::KIND_START, 0, 0, 0, 0);
    send_cmd(taae_pkg::KIND_CHAR, 8'd0, 0, 0, 0);
    send_cmd(taae_pkg::KIND_CHAR, 8'd255, 0, 0, 0);
    send_cmd(taae_pkg::KIND_CHAR, 8'd22, 0, 0, 0);
    send_cmd(taae_pkg::KIND_CHAR, 8'd15, 0, 0, 0);
    send_cmd(taae_pkg::KIND_CHAR, 8'h41, 0, 0, 0);
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h07, 0, 0);  // from unknown to normal
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h07, 0, 0);  // nothing changed, no words
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h0F, 0, 0);  // bold, colours unchanged
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h1F, 0, 0);  // same rendition, background only
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h2A, 0, 0);  // same rendition, both colours
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h8E, 0, 0);  // blink with bright foreground
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h84, 0, 0);  // same rendition, foreground only
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h17, 0, 0);  // blink back to normal
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'hC3, 0, 0);  // blink with dim foreground
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h0B, 0, 0);  // blink to bold
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'hFF, 0, 0);
    send_cmd(taae_pkg::KIND_POS, 0, 0, 8'd0, 8'd0);
    send_cmd(taae_pkg::KIND_POS, 0, 0, 8'd255, 8'd255);
    send_cmd(taae_pkg::KIND_POS, 0, 0, 8'd100, 8'd99);
    send_cmd(taae_pkg::KIND_SAVE, 0, 0, 0, 0);
    send_cmd(taae_pkg::KIND_RESTORE, 0, 0, 0, 0);
    send_cmd(taae_pkg::KIND_FINISH, 0, 0, 0, 0);
    send_cmd(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // bright background reads as bold
    drain_outputs(6);
    write_cfg(1'b1);
    send_cmd(taae_pkg::KIND_START, 0, 0, 0, 0);
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'h80, 0, 0);
    send_cmd(taae_pkg::KIND_COLOUR, 0, 8'hF7, 0, 0);

    // random phases alternating the register; the first runs without gaps or output stalls
    for (int phase = 0; phase < 4; phase++) begin
      drain_outputs(6);
      write_cfg(phase % 2 == 0);
      calm = (phase == 0);
      sent = 0;
      while (sent < 30) send_random();
      // hold the sender until every word of the phase so far is out
      drain_outputs($urandom_range(1, 5));
      while (sent < 55) send_random();
    end
    calm = 1'b0;

    drain_outputs(20);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("text_attribute_to_ansi_escape_encoder test passed");
    end else begin
      $display("text_attribute_to_ansi_escape_encoder test failed");
    end
    $finish;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #6000000;
    $display("text_attribute_to_ansi_escape_encoder test failed");
    $finish;
  end

endmodule
